>>> src/llcfcs_pkg.sv
// shared constants, tables and decode functions for the llc pdu parser
`default_nettype none
package llcfcs_pkg;

  localparam int unsigned MAX_PDU_BITS_DEF = 2048;
  localparam int unsigned LEN_W = 12;
  localparam int unsigned CRC_W = 32;
  localparam int unsigned TAB_W = 6;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] BIT_POS_MAX = {LEN_W{1'b1}};

  // pdu type codes from the first four bits
  localparam logic [3:0] LT_BL_ADATA      = 4'd0;
  localparam logic [3:0] LT_BL_DATA       = 4'd1;
  localparam logic [3:0] LT_BL_UDATA      = 4'd2;
  localparam logic [3:0] LT_BL_ACK        = 4'd3;
  localparam logic [3:0] LT_BL_ADATA_FCS  = 4'd4;
  localparam logic [3:0] LT_BL_DATA_FCS   = 4'd5;
  localparam logic [3:0] LT_BL_UDATA_FCS  = 4'd6;
  localparam logic [3:0] LT_BL_ACK_FCS    = 4'd7;
  localparam logic [3:0] LT_AL_SETUP      = 4'd8;
  localparam logic [3:0] LT_AL_DATA       = 4'd9;
  localparam logic [3:0] LT_AL_UDATA      = 4'd10;
  localparam logic [3:0] LT_AL_ACK_RNR    = 4'd11;
  localparam logic [3:0] LT_AL_RECONNECT  = 4'd12;
  localparam logic [3:0] LT_AL_DISC       = 4'd15;

  // decoded kind codes
  localparam logic [3:0] K_BL_ADATA     = 4'd0;
  localparam logic [3:0] K_BL_DATA      = 4'd1;
  localparam logic [3:0] K_BL_UDATA     = 4'd2;
  localparam logic [3:0] K_BL_ACK       = 4'd3;
  localparam logic [3:0] K_AL_SETUP     = 4'd4;
  localparam logic [3:0] K_AL_DATA      = 4'd5;
  localparam logic [3:0] K_AL_FINAL     = 4'd6;
  localparam logic [3:0] K_AL_UDATA     = 4'd7;
  localparam logic [3:0] K_AL_UFINAL    = 4'd8;
  localparam logic [3:0] K_AL_ACK       = 4'd9;
  localparam logic [3:0] K_AL_RNR       = 4'd10;
  localparam logic [3:0] K_AL_RECONNECT = 4'd11;
  localparam logic [3:0] K_AL_DISC      = 4'd12;
  localparam logic [3:0] K_UNKNOWN      = 4'd13;

  typedef struct packed {
    logic [3:0]       pdu_kind;
    logic             too_short;
    logic             recv_nr;
    logic [7:0]       send_ns;
    logic [7:0]       segment_ss;
    logic [LEN_W-1:0] header_bits;
    logic [LEN_W-1:0] sdu_len;
    logic             has_fcs;
    logic             fcs_bad;
    logic [CRC_W-1:0] received_fcs;
  } llc_res_t;

  function automatic logic [TAB_W-1:0] min_len(input logic [3:0] t);
    logic [TAB_W-1:0] v;
    case (t)
      LT_BL_ADATA:     v = 6'd6;
      LT_BL_DATA:      v = 6'd5;
      LT_BL_UDATA:     v = 6'd4;
      LT_BL_ACK:       v = 6'd5;
      LT_BL_ADATA_FCS: v = 6'd38;
      LT_BL_DATA_FCS:  v = 6'd37;
      LT_BL_UDATA_FCS: v = 6'd36;
      LT_BL_ACK_FCS:   v = 6'd37;
      LT_AL_DATA:      v = 6'd13;
      LT_AL_UDATA:     v = 6'd17;
      LT_AL_ACK_RNR:   v = 6'd1;
      default:         v = 6'd0;
    endcase
    return v;
  endfunction

  function automatic logic [TAB_W-1:0] hdr_len(input logic [3:0] t);
    logic [TAB_W-1:0] v;
    case (t)
      LT_BL_ADATA, LT_BL_ADATA_FCS: v = 6'd6;
      LT_BL_DATA, LT_BL_DATA_FCS:   v = 6'd5;
      LT_BL_ACK, LT_BL_ACK_FCS:     v = 6'd5;
      LT_AL_DATA:                   v = 6'd17;
      LT_AL_UDATA:                  v = 6'd21;
      LT_AL_ACK_RNR:                v = 6'd5;
      default:                      v = 6'd4;
    endcase
    return v;
  endfunction

  function automatic logic is_fcs_type(input logic [3:0] t);
    return (t[3:2] == 2'b01);
  endfunction

  function automatic logic [3:0] kind_of(input logic [3:0] t, input logic sub);
    logic [3:0] k;
    case (t)
      LT_BL_ADATA, LT_BL_ADATA_FCS: k = K_BL_ADATA;
      LT_BL_DATA, LT_BL_DATA_FCS:   k = K_BL_DATA;
      LT_BL_UDATA, LT_BL_UDATA_FCS: k = K_BL_UDATA;
      LT_BL_ACK, LT_BL_ACK_FCS:     k = K_BL_ACK;
      LT_AL_SETUP:                  k = K_AL_SETUP;
      LT_AL_DATA:                   k = sub ? K_AL_FINAL : K_AL_DATA;
      LT_AL_UDATA:                  k = sub ? K_AL_UFINAL : K_AL_UDATA;
      LT_AL_ACK_RNR:                k = sub ? K_AL_ACK : K_AL_RNR;
      LT_AL_RECONNECT:              k = K_AL_RECONNECT;
      LT_AL_DISC:                   k = K_AL_DISC;
      default:                      k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> src/llc_pdu_header_parse_fcs_check_unit.sv
// llc pdu header parser with crc-32 frame check, one pdu bit per request
// result: registered when the request carrying tlast is accepted
// throughput: one bit per cycle; a bit is taken even while a result waits
//   unless that result is stalled, the single output register sets this
// reset: rst_n low clears the bit counter and the output valid; all
//   per-pdu state is reloaded at the first bit of each pdu
`default_nettype none
module llc_pdu_header_parse_fcs_check_unit
  import llcfcs_pkg::*;
#(
  parameter int unsigned MAX_PDU_BITS = MAX_PDU_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // data_bit, pdu_len[11:0], zero pad
  input  wire logic        in_tlast,   // last_bit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // too_short, recv_nr, send_ns, segment_ss,
                                       // header_bits, sdu_len, has_fcs, fcs_bad,
                                       // received_fcs, zero pad
  output logic [3:0]       out_tuser   // pdu_kind
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PDU_BITS);

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [3:0]       type_r, type_nxt;
  logic             sub_r, sub_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] fcs_r, fcs_nxt;
  logic             nr_r, nr_nxt;
  logic [7:0]       ns_r, ns_nxt;
  logic [7:0]       ss_r, ss_nxt;
  logic             out_valid_r;
  llc_res_t         res_r, res_nxt;

  logic             in_acc, first, take, b, fcst, len_ok;
  logic [LEN_W-1:0] pl, pl_clamp, len, sdu_pre, sdu;
  logic [3:0]       type_c;
  logic             sub_c, nr_c;
  logic [CRC_W-1:0] crc_c, fcs_c, crc_a;
  logic [7:0]       ns_c, ss_c;
  logic [TAB_W-1:0] hdr_t, hdr_f;
  logic             shortp, inhdr;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata[0];
  assign pl        = in_tdata[12:1];
  assign first     = (pos_r == '0);

  assign pl_clamp = (32'(pl) > 32'(MAX_PDU_BITS)) ? MAX_LEN : pl;
  assign len      = first ? pl_clamp : len_r;
  assign take     = (pos_r < len);

  // per-pdu state starts clean at the first bit
  assign type_c = first ? 4'd0 : type_r;
  assign sub_c  = first ? 1'b0 : sub_r;
  assign crc_c  = first ? CRC_SEED : crc_r;
  assign fcs_c  = first ? '0 : fcs_r;
  assign nr_c   = first ? 1'b0 : nr_r;
  assign ns_c   = first ? 8'd0 : ns_r;
  assign ss_c   = first ? 8'd0 : ss_r;

  always_comb begin
    type_nxt = type_c;
    sub_nxt  = sub_c;
    crc_nxt  = crc_c;
    fcs_nxt  = fcs_c;
    nr_nxt   = nr_c;
    ns_nxt   = ns_c;
    ss_nxt   = ss_c;
    crc_a    = crc_c;
    fcst     = 1'b0;
    len_ok   = 1'b0;
    hdr_t    = '0;
    sdu_pre  = '0;
    if (take) begin
      // bits land at their own place, missing type bits stay zero
      if (pos_r < LEN_W'(4)) begin
        type_nxt[2'd3 - pos_r[1:0]] = b;
      end
      if (pos_r == LEN_W'(4)) begin
        sub_nxt = b;
      end
      fcst    = is_fcs_type(type_nxt);
      hdr_t   = hdr_len(type_nxt);
      len_ok  = (len >= LEN_W'(min_len(type_nxt)));
      sdu_pre = len - LEN_W'(hdr_t) - LEN_W'(CRC_W);
      // shortened seed when the sdu is under one crc word
      if (pos_r == LEN_W'(3) && fcst && len_ok) begin
        if (sdu_pre == '0) begin
          crc_a = '0;
        end else if (sdu_pre < LEN_W'(CRC_W)) begin
          crc_a = CRC_SEED << (6'd32 - sdu_pre[5:0]);
        end
      end
      case (type_nxt)
        LT_BL_ADATA, LT_BL_ADATA_FCS: begin
          if (pos_r == LEN_W'(4)) nr_nxt = b;
          if (pos_r == LEN_W'(5)) ns_nxt = {7'd0, b};
        end
        LT_BL_DATA, LT_BL_DATA_FCS: begin
          if (pos_r == LEN_W'(4)) ns_nxt = {7'd0, b};
        end
        LT_BL_ACK, LT_BL_ACK_FCS: begin
          if (pos_r == LEN_W'(4)) nr_nxt = b;
        end
        LT_AL_DATA: begin
          if (pos_r >= LEN_W'(6) && pos_r <= LEN_W'(8)) ns_nxt[3'(4'd8 - pos_r[3:0])] = b;
          if (pos_r >= LEN_W'(9) && pos_r <= LEN_W'(16)) ss_nxt[3'(5'd16 - pos_r[4:0])] = b;
        end
        LT_AL_UDATA: begin
          if (pos_r >= LEN_W'(5) && pos_r <= LEN_W'(12)) ns_nxt[3'(4'd12 - pos_r[3:0])] = b;
          if (pos_r >= LEN_W'(13) && pos_r <= LEN_W'(20)) ss_nxt[3'(5'd20 - pos_r[4:0])] = b;
        end
        default: begin
        end
      endcase
      fcs_nxt = {fcs_c[CRC_W-2:0], b};
      crc_nxt = crc_a;
      if (pos_r >= LEN_W'(4) && fcst && len_ok && pos_r >= LEN_W'(hdr_t) &&
          ({1'b0, pos_r} + (LEN_W+1)'(CRC_W) < {1'b0, len})) begin
        crc_nxt = {crc_a[CRC_W-2:0], 1'b0} ^ ((b ^ crc_a[CRC_W-1]) ? CRC_POLY : '0);
      end
    end
  end

  // result decode from the updated state
  always_comb begin
    hdr_f  = hdr_len(type_nxt);
    shortp = (len < LEN_W'(min_len(type_nxt)));
    inhdr  = (len < LEN_W'(hdr_f));
    sdu    = '0;
    if (!shortp && !inhdr && type_nxt <= LT_AL_UDATA && type_nxt != LT_AL_SETUP) begin
      sdu = len - LEN_W'(hdr_f) - (is_fcs_type(type_nxt) ? LEN_W'(CRC_W) : '0);
    end
    res_nxt.pdu_kind     = kind_of(type_nxt, sub_nxt);
    res_nxt.too_short    = shortp;
    res_nxt.recv_nr      = shortp ? 1'b0 : nr_nxt;
    res_nxt.send_ns      = shortp ? 8'd0 : ns_nxt;
    res_nxt.segment_ss   = shortp ? 8'd0 : ss_nxt;
    res_nxt.header_bits  = (shortp || inhdr) ? len : LEN_W'(hdr_f);
    res_nxt.sdu_len      = sdu;
    res_nxt.has_fcs      = !shortp && (is_fcs_type(type_nxt) ||
                           ((type_nxt == LT_AL_DATA || type_nxt == LT_AL_UDATA) && sub_nxt));
    res_nxt.fcs_bad      = !shortp && is_fcs_type(type_nxt) && (~crc_nxt != fcs_nxt);
    res_nxt.received_fcs = (!shortp && is_fcs_type(type_nxt)) ? fcs_nxt : '0;
  end

  always_comb begin
    len_nxt = len;
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_tlast) begin
        pos_nxt = '0;
      end else if (pos_r != BIT_POS_MAX) begin
        pos_nxt = pos_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (in_acc && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r  <= len_nxt;
      type_r <= type_nxt;
      sub_r  <= sub_nxt;
      crc_r  <= crc_nxt;
      fcs_r  <= fcs_nxt;
      nr_r   <= nr_nxt;
      ns_r   <= ns_nxt;
      ss_r   <= ss_nxt;
      if (in_tlast) begin
        res_r <= res_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.pdu_kind;
  assign out_tdata  = {4'd0, res_r.received_fcs, res_r.fcs_bad, res_r.has_fcs,
                       res_r.sdu_len, res_r.header_bits, res_r.segment_ss,
                       res_r.send_ns, res_r.recv_nr, res_r.too_short};

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (pos_r == '0))
    else $error("bit counter not restarted after last bit");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_tlast))
    else $error("result appeared without a last bit");

  a_bad_needs_fcs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.fcs_bad && !res_r.has_fcs))
    else $error("fcs mismatch flagged on pdu without fcs");

  a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.too_short) |-> (res_r.sdu_len == '0 && !res_r.has_fcs))
    else $error("short pdu reports payload");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(res_r)))
    else $error("stalled result lost or changed");

endmodule
`default_nettype wire

>>> tb/llc_pdu_header_parse_fcs_check_unit_tb.sv
// self-checking testbench for the llc pdu header parser with crc-32 frame check
`default_nettype none
module llc_pdu_header_parse_fcs_check_unit_tb;
  import llcfcs_pkg::*;

  localparam logic [3:0] LT_SPARE_13 = 4'd13;
  localparam logic [3:0] LT_SPARE_14 = 4'd14;
  localparam int unsigned MIN_BITS [16] = '{6, 5, 4, 5, 38, 37, 36, 37, 0, 13, 17, 1, 0, 0, 0, 0};
  localparam int unsigned HDR_BITS [16] = '{6, 5, 4, 5, 6, 5, 4, 5, 4, 17, 21, 5, 4, 4, 4, 4};
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_DIR = 26;

  typedef struct packed {
    logic [3:0]  ptype;
    logic        sub;
    logic [11:0] len_f;
    logic [12:0] nbits;
    logic        fcs_ok;
    logic        lit;
    logic [3:0]  kind;
    logic        short_f;
    logic [11:0] hbits;
  } pdu_row_t;

  // type, subtype, pdu_len, bits sent, good fcs, typed-in result, kind, too_short, header_bits
  localparam pdu_row_t DIR_ROWS [NUM_DIR] = '{
    '{LT_BL_UDATA,     1'b0, 12'd4,    13'd4,    1'b0, 1'b1, K_BL_UDATA, 1'b0, 12'd4},
    '{LT_BL_ADATA,     1'b0, 12'd0,    13'd3,    1'b0, 1'b1, K_BL_ADATA, 1'b1, 12'd0},
    '{LT_BL_DATA_FCS,  1'b0, 12'd20,   13'd20,   1'b0, 1'b1, K_BL_DATA,  1'b1, 12'd20},
    '{LT_AL_SETUP,     1'b0, 12'd1,    13'd1,    1'b0, 1'b1, K_AL_SETUP, 1'b0, 12'd1},
    '{LT_AL_ACK_RNR,   1'b0, 12'd3,    13'd3,    1'b0, 1'b1, K_AL_UDATA, 1'b1, 12'd3},
    '{LT_SPARE_13,     1'b0, 12'd4,    13'd4,    1'b0, 1'b1, K_UNKNOWN,  1'b0, 12'd4},
    '{LT_AL_DISC,      1'b0, 12'd50,   13'd50,   1'b0, 1'b1, K_AL_DISC,  1'b0, 12'd4},
    '{LT_SPARE_14,     1'b1, 12'd10,   13'd10,   1'b0, 1'b1, K_UNKNOWN,  1'b0, 12'd4},
    '{LT_BL_ADATA,     1'b1, 12'd6,    13'd6,    1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_DATA,      1'b1, 12'd5,    13'd5,    1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_ACK,       1'b1, 12'd30,   13'd30,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_ADATA_FCS, 1'b1, 12'd38,   13'd38,   1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_DATA_FCS,  1'b0, 12'd47,   13'd47,   1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_UDATA_FCS, 1'b0, 12'd70,   13'd70,   1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_ACK_FCS,   1'b1, 12'd70,   13'd70,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_DATA,      1'b0, 12'd13,   13'd13,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_DATA,      1'b1, 12'd60,   13'd60,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_UDATA,     1'b1, 12'd21,   13'd21,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_UDATA,     1'b0, 12'd60,   13'd60,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_ACK_RNR,   1'b1, 12'd5,    13'd5,    1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_RECONNECT, 1'b0, 12'd12,   13'd12,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_DATA_FCS,  1'b1, 12'd200,  13'd200,  1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_UDATA_FCS, 1'b0, 12'd4095, 13'd40,   1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_ADATA_FCS, 1'b0, 12'd60,   13'd30,   1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_BL_ACK_FCS,   1'b0, 12'd50,   13'd80,   1'b1, 1'b0, K_BL_ADATA, 1'b0, 12'd0},
    '{LT_AL_SETUP,     1'b0, 12'd40,   13'd60,   1'b0, 1'b0, K_BL_ADATA, 1'b0, 12'd0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [3:0]  out_tuser;

  llc_pdu_header_parse_fcs_check_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // parser state mirrored in the bench
  logic [11:0] rx_pos;
  logic [11:0] rx_len;
  logic [3:0]  rx_type;
  logic        rx_sub;
  logic [31:0] rx_crc;
  logic [31:0] rx_fcs;
  logic        hdr_nr;
  logic [7:0]  hdr_ns;
  logic [7:0]  hdr_ss;

  llc_res_t pdu_results_due [$];
  llc_res_t due;
  int fail_cnt = 0;
  int results_checked = 0;
  int pdu_count = 0;
  int bit_count = 0;
  int bl_fcs_count = 0;
  int fcs_bad_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic b);
    return (b ^ c[31]) ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
  endfunction

  // seed is pre-shifted for sdus shorter than the register
  function automatic logic [31:0] crc_start(input int unsigned sdu);
    if (sdu == 0) return '0;
    if (sdu < 32) return CRC_SEED << (32 - sdu);
    return CRC_SEED;
  endfunction

  function automatic bit fcs_kind(input logic [3:0] t);
    return t >= LT_BL_ADATA_FCS && t <= LT_BL_ACK_FCS;
  endfunction

  function automatic logic [3:0] decode_kind(input logic [3:0] t, input logic sub);
    case (t)
      LT_BL_ADATA, LT_BL_ADATA_FCS: return K_BL_ADATA;
      LT_BL_DATA, LT_BL_DATA_FCS:   return K_BL_DATA;
      LT_BL_UDATA, LT_BL_UDATA_FCS: return K_BL_UDATA;
      LT_BL_ACK, LT_BL_ACK_FCS:     return K_BL_ACK;
      LT_AL_SETUP:                  return K_AL_SETUP;
      LT_AL_DATA:                   return sub ? K_AL_FINAL : K_AL_DATA;
      LT_AL_UDATA:                  return sub ? K_AL_UFINAL : K_AL_UDATA;
      LT_AL_ACK_RNR:                return sub ? K_AL_ACK : K_AL_RNR;
      LT_AL_RECONNECT:              return K_AL_RECONNECT;
      LT_AL_DISC:                   return K_AL_DISC;
      default:                      return K_UNKNOWN;
    endcase
  endfunction

  task automatic clear_rx();
    rx_pos = '0;
    rx_type = '0;
    rx_sub = 1'b0;
    rx_crc = CRC_SEED;
    rx_fcs = '0;
    hdr_nr = 1'b0;
    hdr_ns = '0;
    hdr_ss = '0;
  endtask

  task automatic parse_pdu_bit(input logic b, input logic [11:0] pl, input logic lst,
                               output bit done, output llc_res_t r);
    int unsigned i, len, hdr, sdu;
    logic [3:0] t;
    bit shortp, inhdr, fcst;
    done = 1'b0;
    r = '0;
    if (rx_pos == 0) begin
      clear_rx();
      rx_len = (pl > MAX_PDU_BITS_DEF) ? 12'(MAX_PDU_BITS_DEF) : pl;
    end
    if (rx_pos < rx_len) begin
      i = rx_pos;
      len = rx_len;
      if (i < 4) begin
        rx_type[3-i] = b;
        if (i == 3 && fcs_kind(rx_type) && len >= MIN_BITS[rx_type])
          rx_crc = crc_start(len - HDR_BITS[rx_type] - 32);
      end
      if (i == 4) rx_sub = b;
      case (rx_type)
        LT_BL_ADATA, LT_BL_ADATA_FCS: begin
          if (i == 4) hdr_nr = b;
          if (i == 5) hdr_ns = {7'd0, b};
        end
        LT_BL_DATA, LT_BL_DATA_FCS: begin
          if (i == 4) hdr_ns = {7'd0, b};
        end
        LT_BL_ACK, LT_BL_ACK_FCS: begin
          if (i == 4) hdr_nr = b;
        end
        LT_AL_DATA: begin
          if (i >= 6 && i <= 8) hdr_ns[8-i] = b;
          if (i >= 9 && i <= 16) hdr_ss[16-i] = b;
        end
        LT_AL_UDATA: begin
          if (i >= 5 && i <= 12) hdr_ns[12-i] = b;
          if (i >= 13 && i <= 20) hdr_ss[20-i] = b;
        end
        default: ;
      endcase
      rx_fcs = {rx_fcs[30:0], b};
      hdr = HDR_BITS[rx_type];
      if (i >= 4 && fcs_kind(rx_type) && len >= MIN_BITS[rx_type] && i >= hdr && i + 32 < len)
        rx_crc = crc_next(rx_crc, b);
    end
    if (rx_pos != BIT_POS_MAX) rx_pos = rx_pos + 1'b1;
    if (lst) begin
      t = rx_type;
      len = rx_len;
      hdr = HDR_BITS[t];
      shortp = len < MIN_BITS[t];
      inhdr = len < hdr;
      fcst = fcs_kind(t);
      sdu = 0;
      if (!shortp && !inhdr && t <= LT_AL_UDATA && t != LT_AL_SETUP)
        sdu = len - hdr - (fcst ? 32 : 0);
      r.pdu_kind = decode_kind(t, rx_sub);
      r.too_short = shortp;
      if (!shortp) begin
        r.recv_nr = hdr_nr;
        r.send_ns = hdr_ns;
        r.segment_ss = hdr_ss;
      end
      r.header_bits = 12'((shortp || inhdr) ? len : hdr);
      r.sdu_len = 12'(sdu);
      r.has_fcs = !shortp && (fcst || ((t == LT_AL_DATA || t == LT_AL_UDATA) && rx_sub));
      r.fcs_bad = !shortp && fcst && (~rx_crc != rx_fcs);
      if (!shortp && fcst) r.received_fcs = rx_fcs;
      done = 1'b1;
      clear_rx();
    end
  endtask

  task automatic send_pdu(input logic [3:0] t, input logic sub, input logic [11:0] len_f,
                          input int unsigned nbits, input bit fcs_ok, input bit lit,
                          input llc_res_t lit_r);
    bit bits [];
    int unsigned eff, k;
    logic [31:0] c;
    logic [11:0] pl;
    bit done;
    llc_res_t r;
    bits = new[nbits];
    for (k = 0; k < nbits; k++) bits[k] = $urandom_range(1);
    for (k = 0; k < 4 && k < nbits; k++) bits[k] = t[3-k];
    if (nbits > 4) bits[4] = sub;
    eff = (len_f > MAX_PDU_BITS_DEF) ? MAX_PDU_BITS_DEF : len_f;
    // place a matching frame check over the sdu
    if (fcs_ok && fcs_kind(t) && eff >= MIN_BITS[t] && nbits >= eff) begin
      c = crc_start(eff - HDR_BITS[t] - 32);
      for (k = HDR_BITS[t]; k + 32 < eff; k++) c = crc_next(c, bits[k]);
      for (k = 0; k < 32; k++) bits[eff-32+k] = ~c[31-k];
    end
    for (k = 0; k < nbits; k++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      pl = (k == 0) ? len_f : 12'($urandom_range(4095));
      in_tvalid <= 1'b1;
      in_tdata <= {3'b000, pl, bits[k]};
      in_tlast <= (k == nbits - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bit_count++;
      parse_pdu_bit(bits[k], pl, k == nbits - 1, done, r);
      if (done) begin
        pdu_results_due.push_back(lit ? lit_r : r);
        pdu_count++;
        if (r.has_fcs && r.pdu_kind <= K_BL_ACK) bl_fcs_count++;
        if (r.fcs_bad) fcs_bad_count++;
      end
    end
  endtask

  task automatic send_random_pdu();
    logic [3:0] t;
    logic sub;
    int unsigned lo, len, n;
    t = $urandom_range(15);
    sub = $urandom_range(1);
    if ($urandom_range(99) < 80) begin
      lo = (MIN_BITS[t] > HDR_BITS[t]) ? MIN_BITS[t] : HDR_BITS[t];
      len = lo + $urandom_range(60);
      send_pdu(t, sub, 12'(len), len, $urandom_range(99) < 75, 1'b0, '0);
    end else begin
      len = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(70);
      n = $urandom_range(80, 1);
      send_pdu(t, sub, 12'(len), n, $urandom_range(1), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
      fail_cnt++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pdu_results_due.size() == 0) begin
        $display("%0t mismatch result expected none actual kind %0h data %0h",
                 $time, out_tuser, out_tdata);
        fail_cnt++;
      end else begin
        due = pdu_results_due.pop_front();
        check_field("pdu_kind", due.pdu_kind, out_tuser);
        check_field("too_short", due.too_short, out_tdata[0]);
        check_field("recv_nr", due.recv_nr, out_tdata[1]);
        check_field("send_ns", due.send_ns, out_tdata[9:2]);
        check_field("segment_ss", due.segment_ss, out_tdata[17:10]);
        check_field("header_bits", due.header_bits, out_tdata[29:18]);
        check_field("sdu_len", due.sdu_len, out_tdata[41:30]);
        check_field("has_fcs", due.has_fcs, out_tdata[42]);
        check_field("fcs_bad", due.fcs_bad, out_tdata[43]);
        check_field("received_fcs", due.received_fcs, out_tdata[75:44]);
        check_field("pad", 32'd0, out_tdata[79:76]);
        results_checked++;
      end
    end
  end

  initial begin
    int ph, j, start_bits, start_pdus;
    pdu_row_t row;
    llc_res_t lr;
    rx_len = '0;
    clear_rx();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 28 : 0;
      if (ph == 0) begin
        for (j = 0; j < NUM_DIR; j++) begin
          row = DIR_ROWS[j];
          lr = '0;
          lr.pdu_kind = row.kind;
          lr.too_short = row.short_f;
          lr.header_bits = row.hbits;
          send_pdu(row.ptype, row.sub, row.len_f, row.nbits, row.fcs_ok, row.lit, lr);
        end
      end
      if (ph == 2) begin
        // receiver stalls while short pdus keep coming
        hold_req = 1'b1;
        for (j = 0; j < 20; j++) send_pdu(LT_AL_SETUP, 1'b0, 12'd4, 4, 1'b0, 1'b0, '0);
      end
      start_bits = bit_count;
      start_pdus = pdu_count;
      while (bit_count - start_bits < 210 || pdu_count - start_pdus < 5) send_random_pdu();
    end
    in_tvalid <= 1'b0;
    while (pdu_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d pdus in %0d bits, %0d results checked, %0d bl frame checks (%0d bad)",
             pdu_count, bit_count, results_checked, bl_fcs_count, fcs_bad_count);
    $display("idle mixes sender/receiver 28/71, 71/28 and none, plus a %0d-cycle output stall",
             HOLD_CYCLES);
    if (fail_cnt == 0 && pdu_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
